// ===== rtl/core/btc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the barometric temperature compensation block: calibration
// record, register indexes, formula constants and 64-bit product helpers.
// No dependencies.
package btc_pkg;

  localparam int unsigned DW = 64;

  localparam logic [20:0] PRESS_OFFSET = 21'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
  localparam logic signed [26:0] TFINE_OFFSET = 27'sd128000;
  localparam logic signed [28:0] TEMP_ROUND   = 29'sd128;
  localparam logic signed [20:0] TEMP_MIN     = -21'sd4000;
  localparam logic signed [20:0] TEMP_MAX     = 21'sd8500;

  typedef enum logic [1:0] {
    REG_TEMP_CAL = 2'd0,
    REG_PRESS_A  = 2'd1,
    REG_PRESS_B  = 2'd2,
    REG_PRESS_C  = 2'd3
  } cfg_reg_e;

  typedef logic signed [14:0] temp_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Low 64 bits of a 64x64 product are built from three 32x32 partials:
  // the low-by-low product and the low 32 bits of the two cross products.
  function automatic logic [63:0] mul_pp0(input logic [63:0] a, input logic [63:0] b);
    return 64'(a[31:0]) * 64'(b[31:0]);
  endfunction

  function automatic logic [31:0] mul_ppx(input logic [63:0] a, input logic [63:0] b);
    return a[31:0] * b[63:32] + a[63:32] * b[31:0];
  endfunction

  function automatic logic [63:0] mul_join(input logic [63:0] pp0, input logic [31:0] ppx);
    return pp0 + {ppx, 32'h0000_0000};
  endfunction

endpackage

// ===== rtl/core/btc_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for the compensation block: raw sample input, result
// output and calibration register writes. No dependencies.
interface btc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centideg;
  logic        [23:0] pressure_pa;
  logic               divisor_zero;
  modport source (output valid, temperature_centideg, pressure_pa, divisor_zero,
                  input ready);
  modport sink (input valid, temperature_centideg, pressure_pa, divisor_zero,
                output ready);
endinterface

interface btc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/baro_temp_compensation.sv =====
`timescale 1ns / 1ps
// Top level of the barometric temperature and pressure compensation block.
// Depends on btc_pkg, the channel interfaces, btc_front, btc_sdiv, btc_back.

// One result per sample, and a new sample can be taken in every cycle in
// which the output is not stalled. Each sample passes through 10 front stages
// for temperature and the pressure dividend and divisor, 66 for the signed
// 64-bit divider that produces one quotient bit per stage, and 6 for the
// final correction and output register. The divider sets the latency. The
// whole pipeline holds while a result waits at the output; in_if.ready then
// drops. Calibration writes are taken in any cycle and should only be made
// while no sample is in flight.
module baro_temp_compensation import btc_pkg::*; (
  input logic clk,
  input logic rst_n,
  btc_in_if.sink    in_if,
  btc_out_if.source out_if,
  btc_cfg_if.sink   cfg_if
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  cal_t        cal;

  logic        adv;
  logic        fr_valid, dv_valid, bk_valid;
  logic [63:0] fr_num, fr_den, dv_quo;
  logic        dv_zero;
  temp_t       fr_temp, dv_temp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_TEMP_CAL: temp_cal_r <= cfg_if.data[47:0];
        REG_PRESS_A:  press_a_r  <= cfg_if.data;
        REG_PRESS_B:  press_b_r  <= cfg_if.data;
        REG_PRESS_C:  press_c_r  <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = $signed(temp_cal_r[31:16]);
    cal.t3 = $signed(temp_cal_r[47:32]);
    cal.p1 = press_a_r[15:0];
    cal.p2 = $signed(press_a_r[31:16]);
    cal.p3 = $signed(press_a_r[47:32]);
    cal.p4 = $signed(press_a_r[63:48]);
    cal.p5 = $signed(press_b_r[15:0]);
    cal.p6 = $signed(press_b_r[31:16]);
    cal.p7 = $signed(press_b_r[47:32]);
    cal.p8 = $signed(press_b_r[63:48]);
    cal.p9 = $signed(press_c_r);
  end

  assign adv           = !bk_valid || out_if.ready;
  assign in_if.ready   = adv;
  assign cfg_if.ready  = 1'b1;
  assign out_if.valid  = bk_valid;

  btc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_if.valid),
    .raw_t     (in_if.raw_temperature),
    .raw_p     (in_if.raw_pressure),
    .cal       (cal),
    .out_valid (fr_valid),
    .num       (fr_num),
    .den       (fr_den),
    .temp      (fr_temp)
  );

  btc_sdiv u_sdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fr_valid),
    .num       (fr_num),
    .den       (fr_den),
    .temp_in   (fr_temp),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .zero      (dv_zero),
    .temp_out  (dv_temp)
  );

  btc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv_valid),
    .p         (dv_quo),
    .zero      (dv_zero),
    .temp_in   (dv_temp),
    .cal       (cal),
    .out_valid (bk_valid),
    .temp      (out_if.temperature_centideg),
    .pressure  (out_if.pressure_pa),
    .dzero     (out_if.divisor_zero)
  );

endmodule

// ===== rtl/core/btc_front.sv =====
`timescale 1ns / 1ps
// Front pipeline: fine temperature, output temperature, and the dividend and
// divisor of the pressure formula over ten stages. Depends on btc_pkg.
module btc_front import btc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [19:0] raw_t,
  input  logic [19:0] raw_p,
  input  cal_t        cal,
  output logic        out_valid,
  output logic [63:0] num,
  output logic [63:0] den,
  output temp_t       temp
);

  localparam int unsigned NSTG = 10;

  logic [NSTG-1:0] vld_r;

  // stage 1
  logic signed [18:0] dt;
  logic signed [16:0] dd;
  logic signed [33:0] dsq_full;
  logic signed [34:0] m1_nxt, m1_r;
  logic        [31:0] dsq_r;
  // stage 2
  logic signed [36:0] m2_nxt, m2_r;
  logic signed [23:0] v1t_r;
  // stage 3
  logic signed [25:0] tf_nxt, tf_r;
  // stage 4
  logic signed [28:0] tf5;
  logic signed [20:0] tmp_t;
  temp_t              temp_nxt;
  logic signed [26:0] pv;
  logic signed [53:0] pvsq;
  logic        [52:0] pvsq_r;
  logic signed [42:0] pvp5_nxt, pvp5_r, pvp2_nxt, pvp2_r;
  // stage 5
  logic [63:0] pp6_0_r, pp3_0_r;
  logic [31:0] pp6_x_r, pp3_x_r;
  logic signed [42:0] pvp5_s5_r, pvp2_s5_r;
  // stage 6
  logic [63:0] x6_r, x3_r;
  logic signed [42:0] pvp5_s6_r, pvp2_s6_r;
  // stage 7
  logic [63:0] v2_nxt, v2_r, v1p_nxt, v1p_r;
  // stage 8
  logic [63:0] w_r, nu_r;
  // stage 9
  logic [63:0] wp0_r, np0_r;
  logic [31:0] wpx_r, npx_r;
  // stage 10
  logic [63:0] wj;
  logic [63:0] num_r, den_r;

  // raw pressure rides stages 1..7, temperature stages 4..10
  logic [19:0] ap_r [0:6];
  temp_t       tc_r [0:6];

  always_comb begin
    dt       = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
    dd       = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, cal.t1});
    m1_nxt   = dt * cal.t2;
    dsq_full = dd * dd;
    m2_nxt   = $signed({1'b0, dsq_r[31:12]}) * cal.t3;
    tf_nxt   = 26'(v1t_r) + 26'($signed(m2_r[36:14]));

    tf5   = 29'(tf_r) * 29'sd5 + TEMP_ROUND;
    tmp_t = tf5[28:8];
    if (tmp_t < TEMP_MIN) begin
      temp_nxt = 15'(TEMP_MIN);
    end else if (tmp_t > TEMP_MAX) begin
      temp_nxt = 15'(TEMP_MAX);
    end else begin
      temp_nxt = tmp_t[14:0];
    end
    pv       = 27'(tf_r) - TFINE_OFFSET;
    pvsq     = pv * pv;
    pvp5_nxt = pv * cal.p5;
    pvp2_nxt = pv * cal.p2;

    v2_nxt  = x6_r + (64'(pvp5_s6_r) << 17) + (64'(cal.p4) << 35);
    v1p_nxt = 64'($signed(x3_r) >>> 8) + (64'(pvp2_s6_r) << 12);

    wj = mul_join(wp0_r, wpx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r     <= m1_nxt;
      dsq_r    <= dsq_full[31:0];
      ap_r[0]  <= raw_p;

      m2_r     <= m2_nxt;
      v1t_r    <= $signed(m1_r[34:11]);
      ap_r[1]  <= ap_r[0];

      tf_r     <= tf_nxt;
      ap_r[2]  <= ap_r[1];

      tc_r[0]  <= temp_nxt;
      pvsq_r   <= pvsq[52:0];
      pvp5_r   <= pvp5_nxt;
      pvp2_r   <= pvp2_nxt;
      ap_r[3]  <= ap_r[2];

      pp6_0_r   <= mul_pp0(64'(pvsq_r), 64'(cal.p6));
      pp6_x_r   <= mul_ppx(64'(pvsq_r), 64'(cal.p6));
      pp3_0_r   <= mul_pp0(64'(pvsq_r), 64'(cal.p3));
      pp3_x_r   <= mul_ppx(64'(pvsq_r), 64'(cal.p3));
      pvp5_s5_r <= pvp5_r;
      pvp2_s5_r <= pvp2_r;
      ap_r[4]   <= ap_r[3];

      x6_r      <= mul_join(pp6_0_r, pp6_x_r);
      x3_r      <= mul_join(pp3_0_r, pp3_x_r);
      pvp5_s6_r <= pvp5_s5_r;
      pvp2_s6_r <= pvp2_s5_r;
      ap_r[5]   <= ap_r[4];

      v2_r    <= v2_nxt;
      v1p_r   <= v1p_nxt;
      ap_r[6] <= ap_r[5];

      w_r  <= PRESS_BIAS + v1p_r;
      nu_r <= (64'(PRESS_OFFSET - {1'b0, ap_r[6]}) << 31) - v2_r;

      wp0_r <= mul_pp0(w_r, 64'(cal.p1));
      wpx_r <= mul_ppx(w_r, 64'(cal.p1));
      np0_r <= mul_pp0(nu_r, PRESS_SCALE);
      npx_r <= mul_ppx(nu_r, PRESS_SCALE);

      den_r <= 64'($signed(wj) >>> 33);
      num_r <= mul_join(np0_r, npx_r);

      for (int i = 1; i < 7; i++) begin
        tc_r[i] <= tc_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign num       = num_r;
  assign den       = den_r;
  assign temp      = tc_r[6];

endmodule

// ===== rtl/core/btc_sdiv.sv =====
`timescale 1ns / 1ps
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit
// per stage; flags a zero divisor. Depends on btc_pkg.
module btc_sdiv import btc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  temp_t         temp_in,
  output logic          out_valid,
  output logic [DW-1:0] quo,
  output logic          zero,
  output temp_t         temp_out
);

  logic [DW+1:0] vld_r;

  logic [DW-1:0] rem_r  [0:DW];
  logic [DW-1:0] acc_r  [0:DW];
  logic [DW-1:0] mb_r   [0:DW];
  logic          neg_r  [0:DW];
  logic          zero_r [0:DW];
  temp_t         tc_r   [0:DW];

  logic [DW-1:0] rem_sh [0:DW-1];
  logic [DW:0]   diff   [0:DW-1];

  logic [DW-1:0] quo_r;
  logic          zero_q_r;
  temp_t         tc_q_r;

  // Magnitudes are unsigned, so the most negative dividend over -1 comes out
  // as the most negative value again.
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      rem_sh[i] = {rem_r[i][DW-2:0], acc_r[i][DW-1]};
      diff[i]   = {1'b0, rem_sh[i]} - {1'b0, mb_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DW:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= '0;
      acc_r[0]  <= num[DW-1] ? (~num + 1'b1) : num;
      mb_r[0]   <= den[DW-1] ? (~den + 1'b1) : den;
      neg_r[0]  <= num[DW-1] ^ den[DW-1];
      zero_r[0] <= (den == '0);
      tc_r[0]   <= temp_in;
      for (int i = 0; i < DW; i++) begin
        rem_r[i+1]  <= diff[i][DW] ? rem_sh[i] : diff[i][DW-1:0];
        acc_r[i+1]  <= {acc_r[i][DW-2:0], ~diff[i][DW]};
        mb_r[i+1]   <= mb_r[i];
        neg_r[i+1]  <= neg_r[i];
        zero_r[i+1] <= zero_r[i];
        tc_r[i+1]   <= tc_r[i];
      end
      quo_r    <= neg_r[DW] ? (~acc_r[DW] + 1'b1) : acc_r[DW];
      zero_q_r <= zero_r[DW];
      tc_q_r   <= tc_r[DW];
    end
  end

  assign out_valid = vld_r[DW+1];
  assign quo       = quo_r;
  assign zero      = zero_q_r;
  assign temp_out  = tc_q_r;

endmodule

// ===== rtl/core/btc_back.sv =====
`timescale 1ns / 1ps
// Back pipeline: second-order pressure correction after the division,
// saturation and the output register. Depends on btc_pkg.
module btc_back import btc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] p,
  input  logic        zero,
  input  temp_t       temp_in,
  input  cal_t        cal,
  output logic        out_valid,
  output temp_t       temp,
  output logic [23:0] pressure,
  output logic        dzero
);

  localparam int unsigned NSTG = 6;

  logic [NSTG-1:0] vld_r;

  logic [63:0] s;
  logic [63:0] q0_r, r0_r, sq_r, pp8_r, t0_r, x_r, sum_r;
  logic [63:0] pp8_s3_r, pp8_s4_r;
  logic [31:0] qx_r, rx_r, tx_r;
  logic [63:0] pq_nxt;

  logic [63:0] p_r    [0:3];
  logic        zero_r [0:4];
  temp_t       tc_r   [0:4];

  temp_t       temp_r;
  logic [23:0] pa_nxt, pa_r;
  logic        dzero_r;

  always_comb begin
    s      = 64'($signed(p) >>> 13);
    pq_nxt = 64'($signed(sum_r) >>> 8) + (64'(cal.p7) << 4);
    if (zero_r[4] || pq_nxt[63]) begin
      pa_nxt = '0;
    end else if (pq_nxt[62:32] != '0) begin
      pa_nxt = '1;
    end else begin
      pa_nxt = pq_nxt[31:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q0_r      <= mul_pp0(s, s);
      qx_r      <= mul_ppx(s, s);
      r0_r      <= mul_pp0(p, 64'(cal.p8));
      rx_r      <= mul_ppx(p, 64'(cal.p8));
      p_r[0]    <= p;
      zero_r[0] <= zero;
      tc_r[0]   <= temp_in;

      sq_r  <= mul_join(q0_r, qx_r);
      pp8_r <= mul_join(r0_r, rx_r);

      t0_r     <= mul_pp0(sq_r, 64'(cal.p9));
      tx_r     <= mul_ppx(sq_r, 64'(cal.p9));
      pp8_s3_r <= pp8_r;

      x_r      <= mul_join(t0_r, tx_r);
      pp8_s4_r <= pp8_s3_r;

      sum_r <= p_r[3] + 64'($signed(x_r) >>> 25) + 64'($signed(pp8_s4_r) >>> 19);

      temp_r  <= tc_r[4];
      pa_r    <= pa_nxt;
      dzero_r <= zero_r[4];

      for (int i = 1; i < 4; i++) begin
        p_r[i] <= p_r[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        zero_r[i] <= zero_r[i-1];
        tc_r[i]   <= tc_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign temp      = temp_r;
  assign pressure  = pa_r;
  assign dzero     = dzero_r;

endmodule

// ===== rtl/core/btc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the compensation block, attached to the top level
// by a bind. Depends only on the top level's channel signals.
module btc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] out_temp,
  input logic        [23:0] out_press,
  input logic               out_dzero
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temp) &&
    $stable(out_press) && $stable(out_dzero))
    else $error("result changed while stalled");

  // With no result waiting, the block must take a new sample.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_dzero_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dzero |-> out_press == 24'd0)
    else $error("zero divisor with nonzero pressure");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp >= -15'sd4000 && out_temp <= 15'sd8500)
    else $error("temperature outside saturation range");

endmodule

bind baro_temp_compensation btc_checker u_btc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_temp  (out_if.temperature_centideg),
  .out_press (out_if.pressure_pa),
  .out_dzero (out_if.divisor_zero)
);

// ===== dv/baro_temp_compensation_checker.sv =====
`timescale 1ns / 1ps
// Checker for the compensation block: watches the sample, result and
// calibration channels, predicts each result and compares it field by field.
// Depends on btc_pkg and the channel interfaces.
module baro_temp_compensation_checker import btc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  btc_in_if     in_if,
  btc_out_if    out_if,
  btc_cfg_if    cfg_if,
  output int    fail_count,
  output int    results_pending
);

  typedef struct {
    logic signed [14:0] temperature_centideg;
    logic        [23:0] pressure_pa;
    logic               divisor_zero;
  } reading_t;

  logic [47:0] temp_cal;
  logic [63:0] press_a;
  logic [63:0] press_b;
  logic [15:0] press_c;
  reading_t    readings_due[$];

  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
    reading_t r;
    longint at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint v1, v2, d, tf, t, p, num;
    at = longint'(raw_t);
    ap = longint'(raw_p);
    t1 = longint'(temp_cal[15:0]);
    t2 = $signed(temp_cal[31:16]);
    t3 = $signed(temp_cal[47:32]);
    p1 = longint'(press_a[15:0]);
    p2 = $signed(press_a[31:16]);
    p3 = $signed(press_a[47:32]);
    p4 = $signed(press_a[63:48]);
    p5 = $signed(press_b[15:0]);
    p6 = $signed(press_b[31:16]);
    p7 = $signed(press_b[47:32]);
    p8 = $signed(press_b[63:48]);
    p9 = $signed(press_c);

    v1 = (((at >> 3) - (t1 << 1)) * t2) >>> 11;
    d  = (at >> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    t  = (tf * 5 + 128) >>> 8;
    if (t < -4000) t = -4000;
    else if (t > 8500) t = 8500;
    r.temperature_centideg = t[14:0];

    v1 = tf - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.pressure_pa  = '0;
      r.divisor_zero = 1'b1;
    end else begin
      r.divisor_zero = 1'b0;
      p   = 1048576 - ap;
      num = ((p << 31) - v2) * 3125;
      // The one quotient that overflows wraps back to the most negative value.
      if (num == S64_MIN && v1 == -1) p = S64_MIN;
      else p = num / v1;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p  = ((p + v1 + v2) >>> 8) + (p7 << 4);
      if (p < 0) r.pressure_pa = '0;
      else if ((p >>> 8) > 64'sd16777215) r.pressure_pa = 24'hFF_FFFF;
      else r.pressure_pa = p[31:8];
    end
    return r;
  endfunction

  assign results_pending = readings_due.size();

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      temp_cal <= '0;
      press_a  <= '0;
      press_b  <= '0;
      press_c  <= '0;
      fail_count = 0;
      readings_due.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_TEMP_CAL: temp_cal <= cfg_if.data[47:0];
          REG_PRESS_A:  press_a  <= cfg_if.data;
          REG_PRESS_B:  press_b  <= cfg_if.data;
          REG_PRESS_C:  press_c  <= cfg_if.data[15:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        readings_due.push_back(compensate(in_if.raw_temperature, in_if.raw_pressure));
      if (out_if.valid && out_if.ready) begin
        if (readings_due.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          if (out_if.temperature_centideg !== want.temperature_centideg) begin
            $error("temperature_centideg: expected %0d, got %0d",
                   want.temperature_centideg, out_if.temperature_centideg);
            fail_count++;
          end
          if (out_if.pressure_pa !== want.pressure_pa) begin
            $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, out_if.pressure_pa);
            fail_count++;
          end
          if (out_if.divisor_zero !== want.divisor_zero) begin
            $error("divisor_zero: expected %0b, got %0b", want.divisor_zero,
                   out_if.divisor_zero);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/baro_temp_compensation_tb.sv =====
`timescale 1ns / 1ps
// Top of the compensation testbench: clock, reset, calibration phases and
// sample stimulus with random gaps and stalls. Depends on btc_pkg, the
// channel interfaces, the block and baro_temp_compensation_checker.
module baro_temp_compensation_tb;
  import btc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   results_pending;
  int   cycle_count = 0;
  bit   steady_send = 1'b0;
  bit   steady_take = 1'b0;
  int   take_stall = 0;
  logic took_result = 1'b0;

  btc_in_if  in_if ();
  btc_out_if out_if ();
  btc_cfg_if cfg_if ();

  baro_temp_compensation dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  baro_temp_compensation_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 300000) begin
      $display("baro_temp_compensation_tb failed");
      $finish;
    end
  end

  // Result side: after every accepted transaction a new stall length is drawn.
  always @(posedge clk) took_result <= out_if.valid && out_if.ready;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready = 1'b0;
    end else begin
      if (took_result) take_stall = steady_take ? 0 : $urandom_range(0, 12);
      out_if.ready = (take_stall == 0);
      if (take_stall > 0) take_stall--;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic load_cal(input logic [47:0] tc, input logic [63:0] pa,
                          input logic [63:0] pb, input logic [15:0] pc);
    write_reg(REG_TEMP_CAL, {16'(~$urandom_range(0, 65535)), tc});
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_C, {48'(~$urandom_range(0, 65535)), pc});
  endtask

  // Raises valid with the sample and holds it until the transaction is taken.
  task automatic send_sample(input logic [19:0] raw_t, input logic [19:0] raw_p);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.raw_temperature = raw_t;
    in_if.raw_pressure = raw_p;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_if.valid = 1'b0;
    while (results_pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic [19:0] near(input logic [19:0] centre, input int spread);
    return centre + 20'($urandom_range(0, 2 * spread)) - 20'(spread);
  endfunction

  // Typical factory calibration of this sensor family.
  localparam logic [47:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] TYP_C = 16'd6000;

  initial begin
    logic [47:0] tc;
    logic [63:0] pa, pb;
    logic [15:0] pc;
    in_if.valid = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_pressure = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TEMP_CAL;
    cfg_if.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: every divisor is zero.
    send_sample(20'h0_0000, 20'h0_0000);
    send_sample(20'hF_FFFF, 20'hF_FFFF);
    drain();

    load_cal(TYP_T, TYP_A, TYP_B, TYP_C);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h0_0000, 20'h0_0000);
    send_sample(20'hF_FFFF, 20'hF_FFFF);
    send_sample(20'h0_0000, 20'hF_FFFF);
    send_sample(20'hF_FFFF, 20'h0_0000);
    send_sample(20'hA_AAAA, 20'h5_5555);
    send_sample(20'h5_5555, 20'hA_AAAA);
    send_sample(20'd700000, 20'd200000);
    send_sample(20'd350000, 20'd600000);
    drain();

    // Extreme calibrations: all ones, signed extremes, and p1 of zero alone.
    load_cal('1, '1, '1, '1);
    send_sample(20'h0_0000, 20'h0_0000);
    send_sample(20'hF_FFFF, 20'hF_FFFF);
    send_sample(20'd519888, 20'd415148);
    drain();
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {3{16'h7FFF}} << 16 | 64'hFFFF,
             {4{16'h8000}}, 16'h8000);
    send_sample(20'h0_0000, 20'hF_FFFF);
    send_sample(20'hF_FFFF, 20'h0_0000);
    send_sample(20'd519888, 20'd415148);
    drain();
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'h0001},
             {4{16'h7FFF}}, 16'h7FFF);
    send_sample(20'h0_0000, 20'h0_0000);
    send_sample(20'hF_FFFF, 20'hF_FFFF);
    drain();
    load_cal(TYP_T, {TYP_A[63:16], 16'h0000}, TYP_B, TYP_C);
    send_sample(20'd519888, 20'd415148);
    drain();

    for (int phase = 0; phase < 16; phase++) begin
      steady_send = (phase % 4 == 1);
      steady_take = (phase % 4 == 2);
      case (phase % 4)
        0, 1: begin
          // Realistic calibration with small perturbations.
          tc = TYP_T ^ 48'($urandom_range(0, 255));
          pa = TYP_A ^ 64'($urandom_range(0, 255));
          pb = TYP_B ^ {32'($urandom_range(0, 255)), 32'($urandom_range(0, 255))};
          pc = TYP_C ^ 16'($urandom_range(0, 255));
        end
        default: begin
          tc = 48'({$urandom, $urandom});
          pa = {$urandom, $urandom};
          pb = {$urandom, $urandom};
          pc = 16'($urandom);
        end
      endcase
      load_cal(tc, pa, pb, pc);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 3) != 0)
          send_sample(near(20'd519888, 200000), near(20'd415148, 300000));
        else
          send_sample(20'($urandom), 20'($urandom));
      end
      drain();
    end

    if (fail_count == 0)
      $display("baro_temp_compensation_tb passed");
    else
      $display("baro_temp_compensation_tb failed");
    $finish;
  end

endmodule

// ===== baro_temp_compensation.f =====
rtl/core/btc_pkg.sv
rtl/core/btc_if.sv
rtl/core/btc_front.sv
rtl/core/btc_sdiv.sv
rtl/core/btc_back.sv
rtl/core/baro_temp_compensation.sv
rtl/core/btc_checker.sv
dv/baro_temp_compensation_checker.sv
dv/baro_temp_compensation_tb.sv
